// ----- src/color_keyed_sprite_blitter_macros.svh -----
// Assertion macros for the colour-keyed sprite blitter.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef COLOR_KEYED_SPRITE_BLITTER_MACROS_SVH
`define COLOR_KEYED_SPRITE_BLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CKSB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cksb assertion failed");

// Next-cycle implication, checked outside reset.
`define CKSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cksb assertion failed");

`endif

// ----- src/cksb_pkg.sv -----
// Shared types and constants of the colour-keyed sprite blitter.
// Used by the channel interfaces, the top module, cksb_front and cksb_back; depends on nothing.
package cksb_pkg;

  localparam int CFG_W  = 13;
  localparam int PIX_W  = 32;
  localparam int ADDR_W = 24;
  localparam int IDX_W  = 3;

  localparam logic [PIX_W-1:0] TRANSPARENT_KEY = 32'h00FF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]        frame_width;
    logic [CFG_W-1:0]        frame_height;
    logic [CFG_W-1:0]        image_width;
    logic [CFG_W-1:0]        image_height;
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
  } cfg_t;

endpackage

// ----- src/cksb_if.sv -----
// Valid/ready channel interfaces for the sprite pixel input and the frame write output.
// Depends on cksb_pkg for the field widths.
interface cksb_in_if;
  logic                        valid;
  logic                        ready;
  logic [cksb_pkg::PIX_W-1:0]  source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface cksb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [cksb_pkg::ADDR_W-1:0] write_address;
  logic [cksb_pkg::PIX_W-1:0]  write_pixel;
  logic                        last_pixel;

  modport source (output valid, output write_enable, output write_address,
                  output write_pixel, output last_pixel, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_pixel, input last_pixel, output ready);
endinterface

// ----- src/color_keyed_sprite_blitter.sv -----
// Colour-keyed sprite blitter with clipping: a pixel every clock while the queue
// has room, one frame write request for each sprite pixel taken in. Throughput is
// one pixel per cycle whenever the output side takes requests; an accepted pixel
// is held in the queue and then passes through the two-stage address pipeline,
// the address multiplier stage and then the output register, before it appears
// as a write request. Sprite pixels arrive in row-major order on in_ch; each one
// gives exactly one request on out_ch, whose write_enable is low for a pixel equal
// to the transparent key 0xFFFFFF (all 32 bits compared) or lying outside the
// frame, and whose address and pixel are then zero. last_pixel marks the final
// pixel of the sprite, after which the column and row counters start again.
// Configuration may only be written while no request is in flight; it never
// touches the counters. Depends on cksb_pkg, the channel interfaces, cksb_front,
// cksb_queue, cksb_back and the assertion macros header.
module color_keyed_sprite_blitter #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cksb_in_if.sink                      in_ch,
  cksb_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [cksb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cksb_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int CFG_W   = cksb_pkg::CFG_W;
  // The counters hold positions below MAX_DIM.
  localparam int CNT_W   = $clog2(MAX_DIM);
  // Largest size a 13-bit register can hold after saturation to MAX_DIM.
  localparam int CLAMP   = (MAX_DIM > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_DIM;
  localparam int ENTRY_W = 2 * CNT_W + cksb_pkg::PIX_W + 2;
  localparam int Q_DEPTH = 4;

  // Raw register file, as written.
  cksb_pkg::cfg_t cfg_r;
  // Sizes after saturation; a zero sprite size acts as one.
  cksb_pkg::cfg_t cfg_eff;

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= CFG_W'(1);
      cfg_r.frame_height <= CFG_W'(1);
      cfg_r.image_width  <= CFG_W'(1);
      cfg_r.image_height <= CFG_W'(1);
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
    end else if (cfg_we) begin
      case (cksb_pkg::cfg_reg_t'(cfg_index))
        cksb_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        cksb_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        cksb_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata;
        cksb_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        cksb_pkg::REG_ORIGIN_X:     cfg_r.origin_x     <= $signed(cfg_wdata);
        cksb_pkg::REG_ORIGIN_Y:     cfg_r.origin_y     <= $signed(cfg_wdata);
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Frame sizes saturate at MAX_DIM; a zero frame size simply clips every pixel.
  // Sprite sizes saturate the same way, and a zero sprite size is taken as one.
  always_comb begin
    cfg_eff = cfg_r;
    if (cfg_r.frame_width > CFG_W'(CLAMP)) begin
      cfg_eff.frame_width = CFG_W'(CLAMP);
    end
    if (cfg_r.frame_height > CFG_W'(CLAMP)) begin
      cfg_eff.frame_height = CFG_W'(CLAMP);
    end
    if (cfg_r.image_width == '0) begin
      cfg_eff.image_width = CFG_W'(1);
    end else if (cfg_r.image_width > CFG_W'(CLAMP)) begin
      cfg_eff.image_width = CFG_W'(CLAMP);
    end
    if (cfg_r.image_height == '0) begin
      cfg_eff.image_height = CFG_W'(1);
    end else if (cfg_r.image_height > CFG_W'(CLAMP)) begin
      cfg_eff.image_height = CFG_W'(CLAMP);
    end
  end

  // The front end takes a pixel whenever the queue has room, so it keeps
  // accepting while a finished request waits at the output.
  cksb_front #(
    .CNT_W(CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .source_pixel (in_ch.source_pixel),
    .cfg          (cfg_eff),
    .q_full       (q_full),
    .push         (q_push),
    .push_entry   (q_wdata)
  );

  cksb_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // The back end forms the linear address x + y * frame_width, modulo 2^24.
  cksb_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_width   (cfg_eff.frame_width),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .pop_entry     (q_rdata),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .write_enable  (out_ch.write_enable),
    .write_address (out_ch.write_address),
    .write_pixel   (out_ch.write_pixel),
    .last_pixel    (out_ch.last_pixel)
  );

endmodule

// ----- src/cksb_front.sv -----
// Front end: accepts sprite pixels, tracks the sprite column and row, and classifies each pixel.
// Depends on cksb_pkg and the assertion macros header.
`include "color_keyed_sprite_blitter_macros.svh"

module cksb_front #(
  parameter int CNT_W = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cksb_pkg::PIX_W-1:0] source_pixel,
  input  cksb_pkg::cfg_t             cfg,
  input  logic                       q_full,
  output logic                       push,
  output logic [2*CNT_W+cksb_pkg::PIX_W+1:0] push_entry
);

  localparam int CFG_W = cksb_pkg::CFG_W;
  localparam int XY_W  = ((CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W) + 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;

  logic signed [XY_W-1:0] ox_s, oy_s, col_s, row_s, x_s, y_s;
  logic in_frame, opaque, we, end_row, last;
  logic [CNT_W-1:0] x_q, y_q;
  logic [cksb_pkg::PIX_W-1:0] pix_q;

  assign ox_s  = XY_W'(cfg.origin_x);
  assign oy_s  = XY_W'(cfg.origin_y);
  assign col_s = XY_W'(col_r);
  assign row_s = XY_W'(row_r);
  assign x_s   = ox_s + col_s;
  assign y_s   = oy_s + row_s;

  // A negative coordinate is off the frame; otherwise compare against the frame size.
  assign in_frame = !x_s[XY_W-1] && !y_s[XY_W-1]
                 && ($unsigned(x_s) < XY_W'(cfg.frame_width))
                 && ($unsigned(y_s) < XY_W'(cfg.frame_height));
  assign opaque = (source_pixel != cksb_pkg::TRANSPARENT_KEY);
  assign we     = in_frame && opaque;

  // A counter at or past the last column or row, as after a size change, ends it.
  assign end_row = CMP_W'(col_r) >= (CMP_W'(cfg.image_width) - CMP_W'(1));
  assign last    = end_row && (CMP_W'(row_r) >= (CMP_W'(cfg.image_height) - CMP_W'(1)));

  assign x_q   = we ? CNT_W'(x_s) : '0;
  assign y_q   = we ? CNT_W'(y_s) : '0;
  assign pix_q = we ? source_pixel : '0;

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full;
  assign push_entry = {we, last, x_q, y_q, pix_q};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (end_row) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `CKSB_ASSERT_NEXT(a_restart_after_last, push && last, col_r == '0 && row_r == '0)

endmodule

// ----- src/cksb_queue.sv -----
// Short first-in first-out queue between the front and back ends.
// Depends on the assertion macros header only.
`include "color_keyed_sprite_blitter_macros.svh"

module cksb_queue #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  `CKSB_ASSERT_IMPL(a_no_overflow, push, !full)
  `CKSB_ASSERT_IMPL(a_no_underflow, pop, !empty)

endmodule

// ----- src/cksb_back.sv -----
// Back end: turns a classified pixel into a frame write through a multiply stage
// and an output register. Depends on cksb_pkg and the assertion macros header.
`include "color_keyed_sprite_blitter_macros.svh"

module cksb_back #(
  parameter int CNT_W = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cksb_pkg::CFG_W-1:0]  frame_width,
  input  logic                        q_empty,
  output logic                        pop,
  input  logic [2*CNT_W+cksb_pkg::PIX_W+1:0] pop_entry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        write_enable,
  output logic [cksb_pkg::ADDR_W-1:0] write_address,
  output logic [cksb_pkg::PIX_W-1:0]  write_pixel,
  output logic                        last_pixel
);

  localparam int PIX_W  = cksb_pkg::PIX_W;
  localparam int ADDR_W = cksb_pkg::ADDR_W;
  localparam int MUL_W  = CNT_W + cksb_pkg::CFG_W;
  localparam int SUM_W  = MUL_W + 1;

  logic             e_we, e_last;
  logic [CNT_W-1:0] e_x, e_y;
  logic [PIX_W-1:0] e_pix;

  logic             a_valid_r;
  logic             a_we_r, a_last_r;
  logic [CNT_W-1:0] a_x_r;
  logic [MUL_W-1:0] a_prod_r;
  logic [PIX_W-1:0] a_pix_r;

  logic              b_valid_r;
  logic              b_we_r, b_last_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [PIX_W-1:0]  b_pix_r;

  logic a_ready, b_ready, a_load, b_load;
  logic [SUM_W-1:0] sum;

  assign {e_we, e_last, e_x, e_y, e_pix} = pop_entry;

  assign b_ready = !b_valid_r || out_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign pop     = !q_empty && a_ready;
  assign a_load  = pop;
  assign b_load  = a_valid_r && b_ready;

  // A pixel that is not written carries zero coordinates, so its address comes out zero.
  assign sum = SUM_W'(a_prod_r) + SUM_W'(a_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= a_load;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_we_r   <= e_we;
      a_last_r <= e_last;
      a_x_r    <= e_x;
      a_prod_r <= MUL_W'(e_y) * MUL_W'(frame_width);
      a_pix_r  <= e_pix;
    end
    if (b_load) begin
      b_we_r   <= a_we_r;
      b_last_r <= a_last_r;
      b_addr_r <= ADDR_W'(sum);
      b_pix_r  <= a_pix_r;
    end
  end

  assign out_valid     = b_valid_r;
  assign write_enable  = b_we_r;
  assign write_address = b_addr_r;
  assign write_pixel   = b_pix_r;
  assign last_pixel    = b_last_r;

  `CKSB_ASSERT_IMPL(a_idle_write_is_zero, b_valid_r && !b_we_r,
                    b_addr_r == '0 && b_pix_r == '0)

endmodule
